### rtl/assert_macros.svh
// Assertion macros shared by the parser RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain check, sampled on clk_i, off during reset
`define TZP_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Same-cycle implication
`define TZP_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TZP_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tzp_pkg.sv
// Types, codes and constants of the TZ string parser
package tzp_pkg;

  localparam int unsigned QDepth = 2;

  localparam logic [27:0] RULE_TIME_DEFAULT = 28'd7200;
  localparam logic [28:0] DST_SHIFT         = 29'd3600;
  localparam logic [15:0] DIGIT_MAX         = 16'hFFFF;

  localparam logic [1:0] REC_OFFSETS = 2'd0;
  localparam logic [1:0] REC_START   = 2'd1;
  localparam logic [1:0] REC_END     = 2'd2;

  localparam logic [1:0] FORM_JULIAN = 2'd1;
  localparam logic [1:0] FORM_YDAY   = 2'd2;
  localparam logic [1:0] FORM_MWD    = 2'd3;

  typedef enum logic [3:0] {
    PH_LEAD, PH_STDNAME, PH_DSTNAME, PH_RULE, PH_TRAIL, PH_HH, PH_MM, PH_SS,
    PH_JDAY, PH_YDAY, PH_MONTH, PH_WEEK, PH_WDAY
  } phase_e;

  typedef enum logic [1:0] {
    TG_STD, TG_DST, TG_TIME
  } tgt_e;

  // Character class word passed from front to back
  typedef struct packed {
    logic       alpha;
    logic       digit;
    logic       space;
    logic       endm;
    logic       plus;
    logic       minus;
    logic       colon;
    logic       slash;
    logic       dot;
    logic       comma;
    logic       jay;
    logic       em;
    logic [3:0] dval;
    logic       last;
  } cls_t;

  typedef struct packed {
    logic [1:0]  form;
    logic [16:0] day;
    logic [3:0]  month;
    logic [2:0]  week;
    logic [2:0]  wday;
    logic [27:0] time_s;
  } rule_t;

  typedef struct packed {
    phase_e            phase;
    logic              neg;
    logic [15:0]       fa;
    logic [28:0]       oa;
    logic [1:0]        look;
    tgt_e              tgt;
    logic              sel;
    logic [28:0]       std_off;
    logic [28:0]       dst_off;
    rule_t [1:0]       rules;
    logic              failed;
  } st_t;

  typedef struct packed {
    logic        ok;
    logic [28:0] std_off;
    logic [28:0] dst_off;
    rule_t [1:0] rules;
  } snap_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cls_t cls;
  } qhead_t;

endpackage

### rtl/tz_char_if.sv
// Character channel
interface tz_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_text;

  modport source (output valid, output text_char, output end_of_text, input ready);
  modport sink (input valid, input text_char, input end_of_text, output ready);
endinterface

### rtl/tz_rec_if.sv
// Result record channel
interface tz_rec_if;
  logic               valid;
  logic               ready;
  logic [1:0]         record_kind;
  logic               parse_ok;
  logic signed [28:0] std_offset;
  logic signed [28:0] dst_offset;
  logic [1:0]         rule_form;
  logic [16:0]        rule_day;
  logic [3:0]         rule_month;
  logic [2:0]         rule_week;
  logic [2:0]         rule_weekday;
  logic [27:0]        rule_time;
  logic               last_record;

  modport source (output valid, output record_kind, output parse_ok, output std_offset,
                  output dst_offset, output rule_form, output rule_day, output rule_month,
                  output rule_week, output rule_weekday, output rule_time,
                  output last_record, input ready);
  modport sink (input valid, input record_kind, input parse_ok, input std_offset,
                input dst_offset, input rule_form, input rule_day, input rule_month,
                input rule_week, input rule_weekday, input rule_time,
                input last_record, output ready);
endinterface

### rtl/tz_cfg_if.sv
// Configuration write channel
interface tz_cfg_if;
  logic valid;
  logic ready;
  logic west_positive;

  modport source (output valid, output west_positive, input ready);
  modport sink (input valid, input west_positive, output ready);
endinterface

### rtl/posix_tz_string_parser.sv
// POSIX TZ string parser, one character word per cycle while the queue has
// room. The front end classifies each character and queues it (two entries);
// the back end runs the parse state machine at one word per cycle, except
// for the end-of-text step that the final character takes in addition, which
// waits until the record holding register is free. Three records (offsets,
// start rule, end rule) then leave from that holding register; the next
// string's characters are parsed while those records drain, and only its own
// final character waits for them. west_positive resets to 1.
module posix_tz_string_parser (
  input  logic     clk_i,
  input  logic     rst_ni,
  tz_char_if.sink  char_i,
  tz_cfg_if.sink   cfg_i,
  tz_rec_if.source rec_o
);
  import tzp_pkg::*;

  qhead_t head;
  logic   pop, load, emit_free, west_q;
  snap_t  snap;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) west_q <= 1'b1;
    else if (cfg_i.valid) west_q <= cfg_i.west_positive;
  end

  tzp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_i),
    .pop_i  (pop),
    .head_o (head)
  );

  tzp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .west_i      (west_q),
    .emit_free_i (emit_free),
    .load_o      (load),
    .snap_o      (snap)
  );

  tzp_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .snap_i (snap),
    .free_o (emit_free),
    .rec_o  (rec_o)
  );

endmodule

### rtl/tzp_front.sv
// Front end: character classifier and two-entry queue
module tzp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  tz_char_if.sink       char_i,
  input  logic          pop_i,
  output tzp_pkg::qhead_t head_o
);
  import tzp_pkg::*;

  cls_t       cls_in;
  cls_t       q_mem [QDepth];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic [7:0] c;

  assign c = char_i.text_char;

  always_comb begin
    cls_in.alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    cls_in.digit = (c >= 8'h30 && c <= 8'h39);
    cls_in.space = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    cls_in.endm  = 1'b0;
    cls_in.plus  = (c == 8'h2B);
    cls_in.minus = (c == 8'h2D);
    cls_in.colon = (c == 8'h3A);
    cls_in.slash = (c == 8'h2F);
    cls_in.dot   = (c == 8'h2E);
    cls_in.comma = (c == 8'h2C);
    cls_in.jay   = (c == 8'h4A) || (c == 8'h6A);
    cls_in.em    = (c == 8'h4D);
    cls_in.dval  = c[3:0];
    cls_in.last  = char_i.end_of_text;
  end

  assign char_i.ready = (cnt_q != 2'd2);
  assign push = char_i.valid && char_i.ready;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cls_in;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cls   = q_mem[rd_ptr_q];

  `include "assert_macros.svh"
  `TZP_CHECK(a_cnt_range, cnt_q != 2'd3, "queue count out of range")
  `TZP_IMPLY(a_pop_nonempty, pop_i, cnt_q != 2'd0, "pop from empty queue")

endmodule

### rtl/tzp_back.sv
// Back end: parse state machine, one character word per step
module tzp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tzp_pkg::qhead_t head_i,
  output logic           pop_o,
  input  logic           west_i,
  input  logic           emit_free_i,
  output logic           load_o,
  output tzp_pkg::snap_t snap_o
);
  import tzp_pkg::*;

  st_t  st_q, st_d, st_nx;
  logic pend_q, pend_d;
  cls_t end_cls, cls_sel;

  function automatic st_t begin_off(st_t n, tgt_e t, logic ng, logic [1:0] need);
    n.tgt   = t;
    n.neg   = ng;
    n.oa    = '0;
    n.phase = PH_HH;
    n.fa    = '0;
    n.look  = need;
    return n;
  endfunction

  function automatic st_t after_rule(st_t n, cls_t c);
    if (!n.sel && c.comma) begin
      n.sel   = 1'b1;
      n.phase = PH_RULE;
    end else if (n.sel && (c.space || c.endm)) begin
      n.phase = PH_TRAIL;
    end else begin
      n.failed = 1'b1;
    end
    return n;
  endfunction

  function automatic st_t after_date(st_t n, cls_t c);
    if (c.slash) begin
      n = begin_off(n, TG_TIME, 1'b0, 2'd1);
    end else begin
      n.rules[n.sel].time_s = RULE_TIME_DEFAULT;
      n = after_rule(n, c);
    end
    return n;
  endfunction

  function automatic st_t step(st_t s, cls_t c, logic west);
    st_t         n;
    logic [19:0] dv;
    logic [15:0] sat;
    logic [11:0] unit;
    logic [28:0] total, sv, wv;
    logic        blank;
    n     = s;
    blank = c.space || c.endm;
    dv    = {4'd0, s.fa} * 20'd10 + {16'd0, c.dval};
    sat   = (dv > {4'd0, DIGIT_MAX}) ? DIGIT_MAX : dv[15:0];
    unit  = (s.phase == PH_HH) ? 12'd3600 : ((s.phase == PH_MM) ? 12'd60 : 12'd1);
    total = s.oa + {13'd0, s.fa} * {17'd0, unit};
    sv    = s.neg ? -total : total;
    wv    = west ? -sv : sv;
    unique case (s.phase)
      PH_LEAD: begin
        if (c.alpha) n.phase = PH_STDNAME;
        else if (!c.space) n.failed = 1'b1;
      end
      PH_STDNAME, PH_DSTNAME: begin
        if (c.alpha) begin
          n = s;
        end else if (c.plus || c.minus) begin
          n = begin_off(n, (s.phase == PH_STDNAME) ? TG_STD : TG_DST, c.minus, 2'd1);
        end else if (c.digit) begin
          n = begin_off(n, (s.phase == PH_STDNAME) ? TG_STD : TG_DST, 1'b0, 2'd0);
          n.fa = {12'd0, c.dval};
        end else if (s.phase == PH_DSTNAME && c.comma) begin
          n.dst_off = s.std_off + DST_SHIFT;
          n.sel     = 1'b0;
          n.phase   = PH_RULE;
        end else if (s.phase == PH_DSTNAME && blank) begin
          n.dst_off = s.std_off + DST_SHIFT;
          n.phase   = PH_TRAIL;
        end else begin
          n.failed = 1'b1;
        end
      end
      PH_RULE: begin
        if (c.jay) begin
          n.rules[s.sel].form = FORM_JULIAN;
          n.phase = PH_JDAY;
          n.fa    = '0;
          n.look  = 2'd1;
        end else if (c.digit) begin
          n.rules[s.sel].form = FORM_YDAY;
          n.phase = PH_YDAY;
          n.fa    = {12'd0, c.dval};
          n.look  = 2'd0;
        end else if (c.em) begin
          n.rules[s.sel].form = FORM_MWD;
          n.phase = PH_MONTH;
          n.fa    = '0;
          n.look  = 2'd1;
        end else begin
          n.failed = 1'b1;
        end
      end
      PH_TRAIL: begin
        if (!blank) n.failed = 1'b1;
      end
      PH_HH, PH_MM, PH_SS, PH_JDAY, PH_YDAY, PH_MONTH, PH_WEEK, PH_WDAY: begin
        if (c.digit) begin
          n.fa = sat;
          if (s.look != 2'd0) n.look = s.look - 2'd1;
        end else if (s.look != 2'd0) begin
          n.failed = 1'b1;
        end else if ((s.phase == PH_HH || s.phase == PH_MM) && c.colon) begin
          n.oa    = total;
          n.phase = (s.phase == PH_HH) ? PH_MM : PH_SS;
          n.fa    = '0;
          n.look  = 2'd2;
        end else if (s.phase == PH_HH || s.phase == PH_MM || s.phase == PH_SS) begin
          // offset complete: store, then look at what follows
          unique case (s.tgt)
            TG_STD: begin
              n.std_off = wv;
              if (c.alpha) begin
                n.phase = PH_DSTNAME;
              end else begin
                n.dst_off = wv;
                if (c.comma) begin
                  n.sel   = 1'b0;
                  n.phase = PH_RULE;
                end else if (blank) n.phase = PH_TRAIL;
                else n.failed = 1'b1;
              end
            end
            TG_DST: begin
              n.dst_off = wv;
              if (c.comma) begin
                n.sel   = 1'b0;
                n.phase = PH_RULE;
              end else if (blank) n.phase = PH_TRAIL;
              else n.failed = 1'b1;
            end
            TG_TIME: begin
              n.rules[s.sel].time_s = total[27:0];
              n = after_rule(n, c);
            end
            default: n.failed = 1'b1;
          endcase
        end else if (s.phase == PH_JDAY) begin
          n.rules[s.sel].day = {1'b0, s.fa};
          n = after_date(n, c);
        end else if (s.phase == PH_YDAY) begin
          n.rules[s.sel].day = {1'b0, s.fa} + 17'd1;
          n = after_date(n, c);
        end else if (s.phase == PH_MONTH) begin
          if (s.fa == 16'd0 || s.fa > 16'd12 || !c.dot) begin
            n.failed = 1'b1;
          end else begin
            n.rules[s.sel].month = s.fa[3:0];
            n.phase = PH_WEEK;
            n.fa    = '0;
            n.look  = 2'd1;
          end
        end else if (s.phase == PH_WEEK) begin
          if (s.fa == 16'd0 || s.fa > 16'd5 || !c.dot) begin
            n.failed = 1'b1;
          end else begin
            n.rules[s.sel].week = s.fa[2:0];
            n.phase = PH_WDAY;
            n.fa    = '0;
            n.look  = 2'd1;
          end
        end else begin
          if (s.fa > 16'd6) begin
            n.failed = 1'b1;
          end else begin
            n.rules[s.sel].wday = s.fa[2:0] + 3'd1;
            n = after_date(n, c);
          end
        end
      end
      default: n.failed = 1'b1;
    endcase
    return n;
  endfunction

  always_comb begin
    end_cls      = '0;
    end_cls.endm = 1'b1;
    cls_sel      = pend_q ? end_cls : head_i.cls;
    st_nx        = st_q.failed ? st_q : step(st_q, cls_sel, west_i);
  end

  // The final word takes a second step for the end-of-text mark
  always_comb begin
    st_d   = st_q;
    pend_d = pend_q;
    pop_o  = 1'b0;
    load_o = 1'b0;
    if (pend_q) begin
      if (emit_free_i) begin
        load_o = 1'b1;
        st_d   = '0;
        pend_d = 1'b0;
      end
    end else if (head_i.valid) begin
      pop_o = 1'b1;
      st_d  = st_nx;
      if (head_i.cls.last) pend_d = 1'b1;
    end
  end

  always_comb begin
    snap_o.ok      = !st_nx.failed && (st_nx.phase == PH_TRAIL);
    snap_o.std_off = st_nx.std_off;
    snap_o.dst_off = st_nx.dst_off;
    snap_o.rules   = st_nx.rules;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= '0;
      pend_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      pend_q <= pend_d;
    end
  end

  `include "assert_macros.svh"
  `TZP_IMPLY(a_pend_no_pop, pend_q, !pop_o, "word taken during end step")
  `TZP_NEXT(a_clear_after_load, load_o, st_q.phase == PH_LEAD && !st_q.failed,
            "parse state not cleared after records")

endmodule

### rtl/tzp_emit.sv
// Record sequencer: holds one string's results and sends three records
module tzp_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  tzp_pkg::snap_t snap_i,
  output logic           free_o,
  tz_rec_if.source       rec_o
);
  import tzp_pkg::*;

  snap_t      snap_q;
  logic       busy_q, busy_d;
  logic [1:0] idx_q, idx_d;
  rule_t      r;
  logic       fire;

  assign fire   = busy_q && rec_o.ready;
  assign free_o = !busy_q || (fire && idx_q == REC_END);

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (fire) begin
      if (idx_q == REC_END) busy_d = 1'b0;
      else idx_d = idx_q + 2'd1;
    end
    if (load_i) begin
      busy_d = 1'b1;
      idx_d  = REC_OFFSETS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= REC_OFFSETS;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) snap_q <= snap_i;
  end

  always_comb begin
    r = (idx_q == REC_END) ? snap_q.rules[1] : snap_q.rules[0];
    if (!snap_q.ok || idx_q == REC_OFFSETS) r = '0;
  end

  assign rec_o.valid        = busy_q;
  assign rec_o.record_kind  = idx_q;
  assign rec_o.parse_ok     = snap_q.ok;
  assign rec_o.std_offset   = (snap_q.ok && idx_q == REC_OFFSETS) ? snap_q.std_off : '0;
  assign rec_o.dst_offset   = (snap_q.ok && idx_q == REC_OFFSETS) ? snap_q.dst_off : '0;
  assign rec_o.rule_form    = r.form;
  assign rec_o.rule_day     = r.day;
  assign rec_o.rule_month   = r.month;
  assign rec_o.rule_week    = r.week;
  assign rec_o.rule_weekday = r.wday;
  assign rec_o.rule_time    = r.time_s;
  assign rec_o.last_record  = (idx_q == REC_END);

  `include "assert_macros.svh"
  `TZP_IMPLY(a_load_free, load_i && busy_q, idx_q == REC_END && rec_o.ready,
             "results loaded over undelivered records")
  `TZP_IMPLY(a_kind_range, busy_q, idx_q != 2'd3, "record index out of range")

endmodule
